/* rtl/buddy_block_free_coalesce_macros.svh */
// Assertion macros used by the port-level checker of the buddy free block.
`ifndef BUDDY_BLOCK_FREE_COALESCE_MACROS_SVH
`define BUDDY_BLOCK_FREE_COALESCE_MACROS_SVH

// Checks a property at every rising clock edge, reset included.
`define BBFC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

// Checks a property at rising clock edges outside reset.
`define BBFC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

`endif

/* rtl/bbfc_pkg.sv */
// Package with the shared constants, codes and control structures of the buddy free block.
package bbfc_pkg;

    localparam int DEF_PAGE_CAPACITY = 4096;
    localparam int DEF_ORDER_COUNT   = 13;

    localparam int FRAME_W   = 52;
    localparam int ORD_IN_W  = 4;
    localparam int CNT_W     = 13;
    localparam int S_DATA_W  = 56;
    localparam int M_DATA_W  = 88;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 4;
    localparam int WORD_BITS = 64;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_MISALIGNED   = 2'd1,
        ST_OUT_OF_RANGE = 2'd2,
        ST_ALREADY_FREE = 2'd3
    } status_t;

    typedef enum logic {
        REG_BASE_FRAME = 1'b0,
        REG_PAGE_COUNT = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic clr;
        logic load;
        logic offs;
        logic range;
        logic scan_rd;
        logic scan_chk;
        logic mark_rd;
        logic mark_wr;
        logic mcalc;
        logic mrd;
        logic merge;
        logic fin;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic reject;
        logic hit;
        logic last_word;
        logic at_top;
        logic b_inrange;
        logic can_merge;
        logic out_busy;
    } dp_stat_t;

endpackage

/* rtl/bbfc_ctrl.sv */
// Controller state machine that sequences checking, marking and merging of one freed block.
module bbfc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  bbfc_pkg::dp_stat_t  stat,
    output bbfc_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [3:0] {
        CLR, IDLE, OFFS, RANGE, SRD, SCHK, MRDW, MWR, MCALC, MRD, MCHK, FIN, DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            CLR: begin
                cmd.clr = 1'b1;
                if (stat.clr_last) state_next = IDLE;
            end
            IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    state_next = OFFS;
                end
            end
            OFFS: begin
                cmd.offs = 1'b1;
                state_next = RANGE;
            end
            RANGE: begin
                cmd.range = 1'b1;
                state_next = SRD;
            end
            SRD: begin
                if (stat.reject) begin
                    state_next = DONE;
                end else begin
                    cmd.scan_rd = 1'b1;
                    state_next = SCHK;
                end
            end
            SCHK: begin
                cmd.scan_chk = 1'b1;
                priority if (stat.hit) state_next = DONE;
                else if (stat.last_word) state_next = MRDW;
                else state_next = SRD;
            end
            MRDW: begin
                cmd.mark_rd = 1'b1;
                state_next = MWR;
            end
            MWR: begin
                cmd.mark_wr = 1'b1;
                state_next = stat.last_word ? MCALC : MRDW;
            end
            MCALC: begin
                if (stat.at_top) begin
                    state_next = FIN;
                end else begin
                    cmd.mcalc = 1'b1;
                    state_next = MRD;
                end
            end
            MRD: begin
                if (stat.b_inrange) begin
                    cmd.mrd = 1'b1;
                    state_next = MCHK;
                end else begin
                    state_next = FIN;
                end
            end
            MCHK: begin
                if (stat.can_merge) begin
                    cmd.merge = 1'b1;
                    state_next = MCALC;
                end else begin
                    state_next = FIN;
                end
            end
            FIN: begin
                cmd.fin = 1'b1;
                state_next = DONE;
            end
            DONE: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CLR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == IDLE);

endmodule

/* rtl/bbfc_dp.sv */
// Datapath with the free bitmap, head order memory, counts, configuration and result register.
module bbfc_dp #(
    parameter int PAGE_CAPACITY = bbfc_pkg::DEF_PAGE_CAPACITY,
    parameter int ORDER_COUNT   = bbfc_pkg::DEF_ORDER_COUNT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [bbfc_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bbfc_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bbfc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [bbfc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [bbfc_pkg::CFG_DATA_W-1:0]   prdata,
    input  bbfc_pkg::ctrl_cmd_t               cmd,
    output bbfc_pkg::dp_stat_t                stat
);

    localparam int FW     = bbfc_pkg::FRAME_W;
    localparam int CW     = bbfc_pkg::CNT_W;
    localparam int WB     = bbfc_pkg::WORD_BITS;
    localparam int WORDS  = (PAGE_CAPACITY + WB - 1) / WB;
    localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PIDX_W = $clog2(PAGE_CAPACITY);
    localparam int OFF_W  = PIDX_W + 1;
    localparam int LIM_W  = (OFF_W > CW) ? OFF_W : CW;
    localparam int OW     = $clog2(ORDER_COUNT);
    localparam int ORD_W  = (OW > bbfc_pkg::ORD_IN_W) ? OW : bbfc_pkg::ORD_IN_W;
    localparam int SUM_W  = (ORDER_COUNT > CW ? ORDER_COUNT : CW) + 1;

    logic [FW-1:0]  base_reg;
    logic [CW-1:0]  pcount_reg;
    logic           cfg_wr;

    logic [WB-1:0]  bitmap [WORDS];
    logic [OW-1:0]  head_mem [PAGE_CAPACITY];
    logic [WB-1:0]  bm_rdata_reg;
    logic [OW-1:0]  hd_rdata_reg;

    logic [CW-1:0]  cnt_reg [ORDER_COUNT];
    logic [CW-1:0]  total_reg;

    logic [FW-1:0]  frame_reg;
    logic [ORD_W-1:0] order_reg;
    logic [FW:0]    diff_reg;
    logic           bad_ord_reg;
    logic           misal_reg;
    bbfc_pkg::status_t status_reg;
    logic [OFF_W-1:0] off_reg;
    logic [WIDX_W-1:0] widx_reg, first_w_reg, last_w_reg, clr_idx_reg;
    logic [5:0]     lo_reg, hi_reg;
    logic [FW-1:0]  buddy_reg;
    logic           buddy_low_reg;
    logic [OFF_W-1:0] boff_reg;
    logic           binr_reg;
    logic [bbfc_pkg::M_DATA_W-1:0] out_reg;
    logic           out_valid_reg;

    logic [LIM_W-1:0] pc_ext, lim_full;
    logic [OFF_W-1:0] lim;
    logic [FW-1:0]  size52, bsel, buddy;
    logic [FW:0]    bdiff;
    logic [OFF_W-1:0] endv;
    logic           out_rng;
    logic [5:0]     lo, hi;
    logic [WB-1:0]  mask;
    logic [SUM_W-1:0] tot_sum;
    logic [OW-1:0]  ord_idx;

    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[3] == bbfc_pkg::REG_PAGE_COUNT) ?
                    bbfc_pkg::CFG_DATA_W'(pcount_reg) : bbfc_pkg::CFG_DATA_W'(base_reg);

    assign pc_ext   = LIM_W'(pcount_reg);
    assign lim_full = (pc_ext < LIM_W'(PAGE_CAPACITY)) ? pc_ext : LIM_W'(PAGE_CAPACITY);
    assign lim      = OFF_W'(lim_full);
    assign size52   = FW'(1) << order_reg;
    assign bsel     = size52;
    assign buddy    = frame_reg ^ bsel;
    assign bdiff    = {1'b0, buddy} - {1'b0, base_reg};
    assign endv     = OFF_W'(diff_reg) + OFF_W'(size52) - OFF_W'(1);
    assign out_rng  = diff_reg[FW] || (diff_reg[FW-1:0] > FW'(lim)) ||
                      ((FW'(lim) - diff_reg[FW-1:0]) < size52);
    assign ord_idx  = OW'(order_reg);
    assign tot_sum  = SUM_W'(total_reg) + SUM_W'(size52);

    assign lo = (widx_reg == first_w_reg) ? lo_reg : 6'd0;
    assign hi = (widx_reg == last_w_reg) ? hi_reg : 6'd63;
    always_comb begin
        for (int b = 0; b < WB; b++) begin
            mask[b] = (6'(b) >= lo) && (6'(b) <= hi);
        end
    end

    assign stat.clr_last  = (clr_idx_reg == WIDX_W'(WORDS - 1));
    assign stat.reject    = (status_reg != bbfc_pkg::ST_OK);
    assign stat.hit       = |(bm_rdata_reg & mask);
    assign stat.last_word = (widx_reg == last_w_reg);
    assign stat.at_top    = (order_reg >= ORD_W'(ORDER_COUNT - 1));
    assign stat.b_inrange = binr_reg;
    assign stat.can_merge = bm_rdata_reg[boff_reg[5:0]] && (hd_rdata_reg == ord_idx);
    assign stat.out_busy  = out_valid_reg && !m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.clr) begin
            bitmap[clr_idx_reg] <= '0;
        end else if (cmd.mark_wr) begin
            bitmap[widx_reg] <= bm_rdata_reg | mask;
        end
        if (cmd.scan_rd || cmd.mark_rd) begin
            bm_rdata_reg <= bitmap[widx_reg];
        end else if (cmd.mrd) begin
            bm_rdata_reg <= bitmap[WIDX_W'(boff_reg >> 6)];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.merge) begin
            head_mem[boff_reg[PIDX_W-1:0]] <= '0;
        end else if (cmd.fin) begin
            head_mem[off_reg[PIDX_W-1:0]] <= ord_idx;
        end
        if (cmd.mrd) begin
            hd_rdata_reg <= head_mem[boff_reg[PIDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg      <= '0;
            pcount_reg    <= '0;
            total_reg     <= '0;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= bbfc_pkg::ST_OK;
            for (int i = 0; i < ORDER_COUNT; i++) begin
                cnt_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr) begin
                if (paddr[3] == bbfc_pkg::REG_PAGE_COUNT) begin
                    pcount_reg <= pwdata[CW-1:0];
                end else begin
                    base_reg <= pwdata[FW-1:0];
                end
            end
            if (cmd.clr) clr_idx_reg <= clr_idx_reg + WIDX_W'(1);
            if (cmd.load) status_reg <= bbfc_pkg::ST_OK;
            if (cmd.range) begin
                priority if (bad_ord_reg) status_reg <= bbfc_pkg::ST_OUT_OF_RANGE;
                else if (misal_reg) status_reg <= bbfc_pkg::ST_MISALIGNED;
                else if (out_rng) status_reg <= bbfc_pkg::ST_OUT_OF_RANGE;
                else status_reg <= bbfc_pkg::ST_OK;
            end
            if (cmd.scan_chk && stat.hit) status_reg <= bbfc_pkg::ST_ALREADY_FREE;
            if (cmd.mark_wr && stat.last_word) begin
                total_reg <= (tot_sum > SUM_W'({CW{1'b1}})) ? {CW{1'b1}} : CW'(tot_sum);
            end
            if (cmd.merge && cnt_reg[ord_idx] != '0) begin
                cnt_reg[ord_idx] <= cnt_reg[ord_idx] - CW'(1);
            end
            if (cmd.fin && cnt_reg[ord_idx] != {CW{1'b1}}) begin
                cnt_reg[ord_idx] <= cnt_reg[ord_idx] + CW'(1);
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            frame_reg <= s_tdata[FW-1:0];
            order_reg <= ORD_W'(s_tdata[FW+bbfc_pkg::ORD_IN_W-1:FW]);
        end
        if (cmd.offs) begin
            diff_reg    <= {1'b0, frame_reg} - {1'b0, base_reg};
            bad_ord_reg <= (order_reg >= ORD_W'(ORDER_COUNT));
            misal_reg   <= |(frame_reg & (size52 - FW'(1)));
        end
        if (cmd.range) begin
            off_reg     <= OFF_W'(diff_reg);
            first_w_reg <= WIDX_W'(OFF_W'(diff_reg) >> 6);
            widx_reg    <= WIDX_W'(OFF_W'(diff_reg) >> 6);
            last_w_reg  <= WIDX_W'(endv >> 6);
            lo_reg      <= diff_reg[5:0];
            hi_reg      <= endv[5:0];
        end
        if (cmd.scan_chk) begin
            widx_reg <= stat.last_word ? first_w_reg : widx_reg + WIDX_W'(1);
        end
        if (cmd.mark_wr) begin
            widx_reg <= widx_reg + WIDX_W'(1);
        end
        if (cmd.mcalc) begin
            buddy_reg     <= buddy;
            buddy_low_reg <= |(frame_reg & bsel);
            boff_reg      <= OFF_W'(bdiff);
            binr_reg      <= !bdiff[FW] && (bdiff[FW-1:0] < FW'(lim));
        end
        if (cmd.merge) begin
            order_reg <= order_reg + ORD_W'(1);
            if (buddy_low_reg) begin
                frame_reg <= buddy_reg;
                off_reg   <= boff_reg;
            end
        end
        if (cmd.out_load) begin
            if (status_reg != bbfc_pkg::ST_OK) begin
                out_reg <= bbfc_pkg::M_DATA_W'({CW'(0), total_reg, bbfc_pkg::ORD_IN_W'(0),
                                                FW'(0), status_reg});
            end else begin
                out_reg <= bbfc_pkg::M_DATA_W'({cnt_reg[ord_idx], total_reg,
                                                bbfc_pkg::ORD_IN_W'(order_reg), frame_reg,
                                                bbfc_pkg::ST_OK});
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

/* rtl/buddy_block_free_coalesce.sv */
// Top level of the buddy free block with coalescing.
// Input beats on s_* carry a frame number and a block order; each accepted beat
// produces exactly one result beat on m_* with a status, the merged head, its order,
// the free page total and the free block count at that order.
// base_frame and page_count are written over the APB port; the user must write them
// only while the block is idle, which the block itself does not enforce.
// A request is checked for order, alignment and range; the bitmap words it spans are
// scanned for a page already free and then marked, and the block merges with its buddy
// while the buddy lies in range, is free and heads a block of the same order, up to the
// top order. The bitmap holds 64 pages per word; a 4096-page block of order 12 spans
// 64 words. The single-port bitmap memory is read then written a word at a time.
// One request is in flight at a time, and the next beat is taken at the earliest in
// the cycle after a result is loaded.
// After reset the bitmap is cleared one word a cycle, all ceil(PAGE_CAPACITY/64)
// words, while s_tready stays low; configuration writes are taken throughout.
// A finished result waits in an output register while the receiver stalls, and the
// next request may be accepted meanwhile; it finishes only once the register is free.
module buddy_block_free_coalesce #(
    parameter int PAGE_CAPACITY = bbfc_pkg::DEF_PAGE_CAPACITY,
    parameter int ORDER_COUNT   = bbfc_pkg::DEF_ORDER_COUNT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // frame_number [51:0], block_order [55:52]
    input  logic [bbfc_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status [1:0], merged_base [53:2], merged_order [57:54],
    // free_pages [70:58], blocks_at_order [83:71], zero fill [87:84]
    output logic [bbfc_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bbfc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [bbfc_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [bbfc_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready
);

    bbfc_pkg::ctrl_cmd_t cmd;
    bbfc_pkg::dp_stat_t  stat;

    assign pready = 1'b1;

    bbfc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bbfc_dp #(
        .PAGE_CAPACITY (PAGE_CAPACITY),
        .ORDER_COUNT   (ORDER_COUNT)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

/* rtl/bbfc_checker.sv */
// Port-level checker for the buddy free block, bound to the top level.
`include "buddy_block_free_coalesce_macros.svh"

module bbfc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bbfc_pkg::M_DATA_W-1:0] m_tdata
);

    `BBFC_ASSERT_ALWAYS(a_reset_quiet, !aresetn |=> !s_tready && !m_tvalid, "Block not quiet after reset")
    `BBFC_ASSERT(a_one_at_a_time, s_tvalid && s_tready |=> !s_tready, "Second beat taken while busy")
    `BBFC_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "Result beat dropped while stalled")
    `BBFC_ASSERT(a_reject_zero, m_tvalid && m_tdata[1:0] != 2'd0 |-> m_tdata[57:54] == 4'd0 && m_tdata[83:71] == 13'd0, "Rejected beat carries merge data")
    `BBFC_ASSERT(a_ok_count, m_tvalid && m_tdata[1:0] == 2'd0 |-> m_tdata[83:71] != 13'd0, "Accepted free shows no block at its order")

endmodule

bind buddy_block_free_coalesce bbfc_checker u_bbfc_checker (.*);
